@@ sv/owpc_pkg.sv @@
// Package for the one-line pulse-width command sender.
// Holds the item, result and register types, the command codes and the duration helper.
// No dependencies; every other file imports it.
package owpc_pkg;

  // Status codes reported with each result
  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_INVALID = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  // Command kinds on in_kind
  typedef enum logic [1:0] {
    KIND_PLAY   = 2'd0,
    KIND_VOLUME = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_RAW    = 2'd3
  } kind_t;

  // Command byte limits
  localparam logic [7:0] PLAY_MAX  = 8'hDF;
  localparam logic [7:0] VOL_MIN   = 8'hE0;
  localparam logic [7:0] VOL_MAX   = 8'hEF;
  localparam logic [7:0] STOP_BYTE = 8'hFE;

  // Register map indexes
  localparam logic [2:0] REG_LONG  = 3'd0;
  localparam logic [2:0] REG_SHORT = 3'd1;
  localparam logic [2:0] REG_START = 3'd2;
  localparam logic [2:0] REG_PRE   = 3'd3;
  localparam logic [2:0] REG_GAP   = 3'd4;

  // Register reset values, in ticks
  localparam logic [15:0] LONG_RST  = 16'd600;
  localparam logic [15:0] SHORT_RST = 16'd200;
  localparam logic [15:0] START_RST = 16'd5000;
  localparam logic [15:0] PRE_RST   = 16'd5000;
  localparam logic [15:0] GAP_RST   = 16'd2000;

  // Bits in one frame
  localparam logic [3:0] FRAME_BITS = 4'd8;

  // Frame sequencer phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_PRE   = 6'b000010,
    PH_START = 6'b000100,
    PH_BITHI = 6'b001000,
    PH_BITLO = 6'b010000,
    PH_GAP   = 6'b100000
  } phase_t;

  // Timing registers
  typedef struct packed {
    logic [15:0] long_ph;
    logic [15:0] short_ph;
    logic [15:0] start_low;
    logic [15:0] pre_high;
    logic [15:0] gap_high;
  } cfg_t;

  // Classified item: a tick, or a command with its check result and byte
  typedef struct packed {
    logic       is_cmd;
    logic       ok;
    logic [7:0] cmd_byte;
  } item_t;

  // Head of the item queue as seen by the sequencer
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  // One result beat
  typedef struct packed {
    logic    line;
    logic    sending;
    logic    frame_done;
    status_t status;
  } result_t;

  // A zero duration counts as one tick
  function automatic logic [15:0] dur(input logic [15:0] v);
    dur = (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

@@ sv/owpc_front.sv @@
// Front end of the command sender: classifies input beats and queues them.
// Two-entry queue toward the frame sequencer. Depends on owpc_pkg.
module owpc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic            in_func,
  input  logic [1:0]      in_kind,
  input  logic [7:0]      in_value,
  output owpc_pkg::qhead_t head,
  input  logic            head_pop
);
  import owpc_pkg::*;

  item_t      cls;
  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  // Check the command and pick the byte to send
  always_comb begin
    cls.is_cmd   = in_func;
    cls.ok       = 1'b1;
    cls.cmd_byte = in_value;
    unique case (kind_t'(in_kind))
      KIND_PLAY:   cls.ok = (in_value <= PLAY_MAX);
      KIND_VOLUME: cls.ok = (in_value >= VOL_MIN) && (in_value <= VOL_MAX);
      KIND_STOP:   cls.cmd_byte = STOP_BYTE;
      KIND_RAW:    cls.ok = 1'b1;
      default:     cls.ok = 1'b1;
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = head_pop && (cnt_r != 2'd0);

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

endmodule

@@ sv/owpc_back.sv @@
// Back end of the command sender: frame sequencer and result queue.
// Takes one classified beat per cycle while the result queue has room, updates line state, queues the result.
// Depends on owpc_pkg.
module owpc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  owpc_pkg::cfg_t   cfg,
  input  owpc_pkg::qhead_t head,
  output logic             head_pop,
  output logic             empty,
  input  logic             pop,
  output owpc_pkg::result_t res
);
  import owpc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        line_r, line_nxt;
  logic [15:0] tick_dec;
  logic [3:0]  bits_dec;
  logic        take;
  result_t     new_res;
  status_t     status;
  logic        done;

  result_t     oq_r [2];
  logic        owr_r, owr_nxt;
  logic        ord_r, ord_nxt;
  logic [1:0]  ocnt_r, ocnt_nxt;
  logic        do_opop;

  assign do_opop  = pop && (ocnt_r != 2'd0);
  assign take     = head.valid && ((ocnt_r != 2'd2) || do_opop);
  assign head_pop = take;
  assign tick_dec = tick_r - 16'd1;
  assign bits_dec = bits_r - 4'd1;

  // Step the frame sequencer for one beat
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    tick_nxt  = tick_r;
    line_nxt  = line_r;
    status    = ST_NONE;
    done      = 1'b0;
    if (take) begin
      if (head.item.is_cmd) begin
        if (!head.item.ok) begin
          status = ST_INVALID;
        end else if (phase_r != PH_IDLE) begin
          status = ST_BUSY;
        end else begin
          status    = ST_OK;
          shift_nxt = head.item.cmd_byte;
          bits_nxt  = FRAME_BITS;
          if (!line_r) begin
            phase_nxt = PH_PRE;
            line_nxt  = 1'b1;
            tick_nxt  = dur(cfg.pre_high);
          end else begin
            phase_nxt = PH_START;
            line_nxt  = 1'b0;
            tick_nxt  = dur(cfg.start_low);
          end
        end
      end else if (phase_r != PH_IDLE) begin
        tick_nxt = tick_dec;
        if (tick_dec == 16'd0) begin
          unique case (phase_r)
            PH_PRE: begin
              phase_nxt = PH_START;
              line_nxt  = 1'b0;
              tick_nxt  = dur(cfg.start_low);
            end
            PH_START: begin
              phase_nxt = PH_BITHI;
              line_nxt  = 1'b1;
              tick_nxt  = shift_r[0] ? dur(cfg.long_ph) : dur(cfg.short_ph);
            end
            PH_BITHI: begin
              phase_nxt = PH_BITLO;
              line_nxt  = 1'b0;
              tick_nxt  = shift_r[0] ? dur(cfg.short_ph) : dur(cfg.long_ph);
            end
            PH_BITLO: begin
              shift_nxt = {1'b0, shift_r[7:1]};
              bits_nxt  = bits_dec;
              line_nxt  = 1'b1;
              if (bits_dec != 4'd0) begin
                phase_nxt = PH_BITHI;
                tick_nxt  = shift_r[1] ? dur(cfg.long_ph) : dur(cfg.short_ph);
              end else begin
                phase_nxt = PH_GAP;
                tick_nxt  = dur(cfg.gap_high);
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              line_nxt  = 1'b1;
              tick_nxt  = 16'd0;
              done      = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    new_res.line       = line_nxt;
    new_res.sending    = (phase_nxt != PH_IDLE);
    new_res.frame_done = done;
    new_res.status     = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= 8'd0;
      bits_r  <= 4'd0;
      tick_r  <= 16'd0;
      line_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      tick_r  <= tick_nxt;
      line_r  <= line_nxt;
    end
  end

  // Advance result queue pointers and count
  always_comb begin
    owr_nxt  = take ? ~owr_r : owr_r;
    ord_nxt  = do_opop ? ~ord_r : ord_r;
    ocnt_nxt = ocnt_r;
    if (take && !do_opop) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (do_opop && !take) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      owr_r  <= owr_nxt;
      ord_r  <= ord_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  // Hold the result beat until popped
  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[owr_r] <= new_res;
    end
  end

  assign empty = (ocnt_r == 2'd0);
  assign res   = oq_r[ord_r];

endmodule

@@ sv/one_wire_pulse_width_command_sender_top.sv @@
// One-line pulse-width command sender. Takes one beat (a microsecond tick or a
// command) per clock while not full and returns one result beat per input beat, in
// order. The taken beat is written into the classifier queue; from its head the
// frame sequencer carries it into the result queue, once that queue has room.
// Sustained rate is one beat per cycle while neither queue stalls. The user must
// write timing registers over the APB port only while no beat is in flight; the
// block itself does not enforce this. A zero value counts as one tick.
// Top level: register file and glue; depends on owpc_pkg, owpc_front, owpc_back.
module one_wire_pulse_width_command_sender_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_func,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_value,
  output logic        empty,
  input  logic        pop,
  output logic        out_line,
  output logic        out_sending,
  output logic        out_frame_done,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import owpc_pkg::*;

  cfg_t    cfg_r;
  logic    cfg_wr;
  qhead_t  head;
  logic    head_pop;
  result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ph   <= LONG_RST;
      cfg_r.short_ph  <= SHORT_RST;
      cfg_r.start_low <= START_RST;
      cfg_r.pre_high  <= PRE_RST;
      cfg_r.gap_high  <= GAP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LONG:  cfg_r.long_ph   <= pwdata[15:0];
        REG_SHORT: cfg_r.short_ph  <= pwdata[15:0];
        REG_START: cfg_r.start_low <= pwdata[15:0];
        REG_PRE:   cfg_r.pre_high  <= pwdata[15:0];
        REG_GAP:   cfg_r.gap_high  <= pwdata[15:0];
        default:   cfg_r <= cfg_r;
      endcase
    end
  end

  // Read back timing registers
  always_comb begin
    unique case (paddr[4:2])
      REG_LONG:  prdata = {16'd0, cfg_r.long_ph};
      REG_SHORT: prdata = {16'd0, cfg_r.short_ph};
      REG_START: prdata = {16'd0, cfg_r.start_low};
      REG_PRE:   prdata = {16'd0, cfg_r.pre_high};
      REG_GAP:   prdata = {16'd0, cfg_r.gap_high};
      default:   prdata = 32'd0;
    endcase
  end

  owpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_func  (in_func),
    .in_kind  (in_kind),
    .in_value (in_value),
    .head     (head),
    .head_pop (head_pop)
  );

  owpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .head_pop (head_pop),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign out_line       = res.line;
  assign out_sending    = res.sending;
  assign out_frame_done = res.frame_done;
  assign out_status     = res.status;

endmodule

@@ sv/owpc_checker.sv @@
// Port-level checker for the command sender, bound to the top level.
// Depends on owpc_pkg for status codes.
module owpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       out_line,
  input logic       out_sending,
  input logic       out_frame_done,
  input logic [1:0] out_status
);
  import owpc_pkg::*;

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // Frame end leaves the line high and the sender idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_frame_done |-> !out_sending && out_line)
    else $error("frame_done without idle high line");

  // An accepted command starts a frame
  a_ok_sending: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_status == ST_OK) |-> out_sending)
    else $error("accepted command without frame");

  // A busy reject only happens inside a frame
  a_busy_sending: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_status == ST_BUSY) |-> out_sending && !out_frame_done)
    else $error("busy reject while idle");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_status) && $stable(out_line))
    else $error("result beat changed while stalled");

endmodule

bind one_wire_pulse_width_command_sender_top owpc_checker u_owpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_line       (out_line),
  .out_sending    (out_sending),
  .out_frame_done (out_frame_done),
  .out_status     (out_status)
);

@@ tb/one_wire_pulse_width_command_sender_top_test.sv @@
// Self-checking testbench for the one-line pulse-width command sender top level.
// Drives tick and command beats, predicts every result beat and checks them in order.
// Depends on owpc_pkg and one_wire_pulse_width_command_sender_top.
module one_wire_pulse_width_command_sender_top_test;
  import owpc_pkg::*;

  localparam int IDLE_PCT    = 36;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;
  localparam int REG_COUNT   = 5;
  localparam int ADDR_SLOTS  = 8;
  localparam int MAX_REPORTS = 10;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BEATS = 150;
  localparam int NOISE_PCT   = 3;
  localparam longint TIMEOUT = 64'd20_000_000;

  typedef struct packed {
    logic       func;
    kind_t      kind;
    logic [7:0] value;
  } cmd_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_func = 1'b0;
  logic [1:0]  in_kind = 2'd0;
  logic [7:0]  in_value = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_line;
  logic        out_sending;
  logic        out_frame_done;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  one_wire_pulse_width_command_sender_top dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_func(in_func), .in_kind(in_kind), .in_value(in_value),
    .empty(empty), .pop(pop),
    .out_line(out_line), .out_sending(out_sending),
    .out_frame_done(out_frame_done), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Free-running clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be sent and line results waiting to arrive
  cmd_beat_t beats_to_send[$];
  result_t   line_results_due[$];

  // Shadow of the sender: timing registers and frame sequencer state
  logic [15:0] tmr [REG_COUNT] = '{LONG_RST, SHORT_RST, START_RST, PRE_RST, GAP_RST};
  phase_t      ph = PH_IDLE;
  logic [7:0]  sh_byte = 8'd0;
  logic [3:0]  bits_todo = 4'd0;
  logic [15:0] cnt = 16'd0;
  logic        lvl = 1'b0;

  int  mismatches = 0;
  int  beats_queued = 0;
  int  beats_in = 0;
  int  results_seen = 0;
  int  cmd_ok = 0;
  int  cmd_invalid = 0;
  int  cmd_busy = 0;
  int  frames_done = 0;
  int  reg_writes = 0;
  bit  no_gaps = 1'b0;
  int  hold_asks = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  logic in_taken = 1'b0;

  function automatic void note_miss(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Zero in a timing register counts as one tick
  function automatic logic [15:0] tick_len(input int idx);
    return (tmr[idx] == 16'd0) ? 16'd1 : tmr[idx];
  endfunction

  function automatic void enter_phase(input phase_t p, input logic level, input logic [15:0] n);
    ph  = p;
    lvl = level;
    cnt = n;
  endfunction

  // Load the high half of the next bit cell
  function automatic void begin_bit();
    enter_phase(PH_BITHI, 1'b1, sh_byte[0] ? tick_len(REG_LONG) : tick_len(REG_SHORT));
  endfunction

  // Advance the line shadow by one beat and return the result it produces
  function automatic result_t advance_line(input cmd_beat_t b);
    result_t    r;
    logic       ok;
    logic [7:0] code;
    r.frame_done = 1'b0;
    r.status     = ST_NONE;
    ok           = 1'b1;
    code         = b.value;
    if (b.func) begin
      case (b.kind)
        KIND_PLAY:   ok = (b.value <= PLAY_MAX);
        KIND_VOLUME: ok = (b.value >= VOL_MIN) && (b.value <= VOL_MAX);
        KIND_STOP:   code = STOP_BYTE;
        default: ;
      endcase
      if (!ok) begin
        r.status = ST_INVALID;
        cmd_invalid++;
      end else if (ph != PH_IDLE) begin
        r.status = ST_BUSY;
        cmd_busy++;
      end else begin
        r.status  = ST_OK;
        cmd_ok++;
        sh_byte   = code;
        bits_todo = FRAME_BITS;
        if (!lvl) enter_phase(PH_PRE, 1'b1, tick_len(REG_PRE));
        else enter_phase(PH_START, 1'b0, tick_len(REG_START));
      end
    end else if (ph != PH_IDLE) begin
      cnt = cnt - 16'd1;
      if (cnt == 16'd0) begin
        case (ph)
          PH_PRE:   enter_phase(PH_START, 1'b0, tick_len(REG_START));
          PH_START: begin_bit();
          PH_BITHI: enter_phase(PH_BITLO, 1'b0,
                                sh_byte[0] ? tick_len(REG_SHORT) : tick_len(REG_LONG));
          PH_BITLO: begin
            sh_byte   = sh_byte >> 1;
            bits_todo = bits_todo - 4'd1;
            if (bits_todo != 4'd0) begin_bit();
            else enter_phase(PH_GAP, 1'b1, tick_len(REG_GAP));
          end
          default: begin
            enter_phase(PH_IDLE, 1'b1, 16'd0);
            r.frame_done = 1'b1;
            frames_done++;
          end
        endcase
      end
    end
    r.line    = lvl;
    r.sending = (ph != PH_IDLE);
    return r;
  endfunction

  // Ticks from a command up to the end of its gap, every bit cell being long plus short
  function automatic int frame_ticks(input bit with_pre);
    int n;
    n = int'(tick_len(REG_START)) + 8 * (int'(tick_len(REG_LONG)) + int'(tick_len(REG_SHORT)))
        + int'(tick_len(REG_GAP));
    if (with_pre) n += int'(tick_len(REG_PRE));
    return n;
  endfunction

  // Sample input acceptance at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && push && !full;
  end

  // Driver: retire the taken beat, then offer the next one or idle
  always @(negedge clk) begin
    if (in_taken) begin
      line_results_due.push_back(advance_line(beats_to_send.pop_front()));
      beats_in++;
    end
    if (!rst_n || beats_to_send.size() == 0) begin
      push <= 1'b0;
    end else begin
      push     <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      in_func  <= beats_to_send[0].func;
      in_kind  <= beats_to_send[0].kind;
      in_value <= beats_to_send[0].value;
    end
  end

  // Receiver: random pops, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (line_results_due.size() == 0) begin
        note_miss($sformatf("result with nothing expected: line %0b sending %0b done %0b %s%0d",
                            out_line, out_sending, out_frame_done, "status ", out_status));
      end else begin
        want = line_results_due.pop_front();
        if (out_line !== want.line || out_sending !== want.sending ||
            out_frame_done !== want.frame_done || out_status !== want.status) begin
          note_miss($sformatf({"result %0d: expected line %0b sending %0b done %0b status %0d,",
                               " got line %0b sending %0b done %0b status %0d"},
                              results_seen, want.line, want.sending, want.frame_done,
                              want.status, out_line, out_sending, out_frame_done,
                              out_status));
        end
      end
    end
  end

  task automatic queue_beat(input logic func, input kind_t kind, input logic [7:0] value);
    cmd_beat_t b;
    b.func  = func;
    b.kind  = kind;
    b.value = value;
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  // Tick with junk in the command fields
  task automatic queue_tick();
    queue_beat(1'b0, kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_noise_cmd();
    queue_beat(1'b1, kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // One command followed by enough ticks to finish its frame, with optional noise
  task automatic run_frame(input kind_t kind, input logic [7:0] value, input bit with_pre,
                           input int noise_pct);
    int n;
    n = frame_ticks(with_pre);
    queue_beat(1'b1, kind, value);
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct) queue_noise_cmd();
      queue_tick();
    end
  endtask

  task automatic run_valid_frame();
    kind_t      k;
    logic [7:0] v;
    k = kind_t'($urandom_range(0, 3));
    case (k)
      KIND_PLAY:   v = 8'($urandom_range(0, PLAY_MAX));
      KIND_VOLUME: v = 8'($urandom_range(VOL_MIN, VOL_MAX));
      default:     v = 8'($urandom_range(0, 255));
    endcase
    run_frame(k, v, 1'b0, NOISE_PCT);
  endtask

  // Wait until every beat is sent and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (beats_to_send.size() != 0 || line_results_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (idx < REG_COUNT) tmr[idx] = data[15:0];
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check(input int idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 5'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata[15:0] !== tmr[idx])
      note_miss($sformatf("register %0d readback: expected %0d, got %0d",
                          idx, tmr[idx], prdata[15:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly short durations so frames stay brief; junk in the upper data bits
  function automatic logic [31:0] rand_cfg_word();
    int r;
    int low;
    r = $urandom_range(0, 99);
    if (r < 70) low = $urandom_range(0, 4);
    else if (r < 90) low = $urandom_range(5, 12);
    else low = $urandom_range(13, 24);
    return {16'($urandom), 16'(low)};
  endfunction

  // Stimulus sequence
  initial begin
    int i;
    int p;
    int start_cnt;
    int r;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Check reset values of the timing registers
    for (i = 0; i < REG_COUNT; i++) cfg_read_check(i);

    // Reset state: idle tick on a low line and rejections
    queue_tick();
    queue_beat(1'b1, KIND_PLAY, VOL_MIN);
    queue_beat(1'b1, KIND_VOLUME, 8'h00);
    drain();

    // Short timing, then a frame with preamble and rejections during it
    cfg_write(REG_LONG, 32'd4);
    cfg_write(REG_SHORT, 32'd2);
    cfg_write(REG_START, 32'd3);
    cfg_write(REG_PRE, 32'd5);
    cfg_write(REG_GAP, 32'd2);
    queue_beat(1'b1, KIND_PLAY, 8'h00);
    queue_beat(1'b1, KIND_RAW, 8'hFF);
    queue_beat(1'b1, KIND_VOLUME, VOL_MAX + 8'd1);
    repeat (frame_ticks(1'b1)) queue_tick();
    queue_tick();
    drain();

    // Zero durations read as one tick, junk upper data bits, writes past the map ignored
    cfg_write(REG_LONG, 32'h0000_0001);
    cfg_write(REG_SHORT, 32'hFFFF_0000);
    cfg_write(REG_START, 32'hA5A5_0003);
    cfg_write(REG_PRE, 32'h5A5A_0000);
    cfg_write(REG_GAP, 32'h0000_0000);
    for (i = REG_COUNT; i < ADDR_SLOTS; i++) cfg_write(i, $urandom);
    for (i = 0; i < REG_COUNT; i++) cfg_read_check(i);
    queue_beat(1'b1, KIND_STOP, 8'($urandom_range(0, 255)));
    queue_beat(1'b1, KIND_STOP, 8'($urandom_range(0, 255)));
    repeat (frame_ticks(1'b0) + 2) queue_tick();
    drain();

    // Boundary command values on short timing
    cfg_write(REG_LONG, 32'd3);
    cfg_write(REG_SHORT, 32'd1);
    cfg_write(REG_START, 32'd2);
    cfg_write(REG_PRE, 32'd1);
    cfg_write(REG_GAP, 32'd1);
    run_frame(KIND_VOLUME, VOL_MIN, 1'b0, 0);
    run_frame(KIND_VOLUME, VOL_MAX, 1'b0, 0);
    run_frame(KIND_PLAY, PLAY_MAX, 1'b0, 0);
    run_frame(KIND_RAW, 8'h00, 1'b0, 0);
    run_frame(KIND_RAW, 8'hFF, 1'b0, 0);
    queue_beat(1'b1, KIND_PLAY, 8'hFF);
    queue_beat(1'b1, KIND_VOLUME, PLAY_MAX);
    drain();

    // Random phases: mostly complete frames, some stray commands and tick bursts
    for (p = 0; p < RAND_PHASES; p++) begin
      for (i = 0; i < REG_COUNT; i++) cfg_write(i, rand_cfg_word());
      no_gaps = (p == 2);
      if (p == 4) hold_asks++;
      start_cnt = beats_queued;
      while (beats_queued - start_cnt < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          run_valid_frame();
          repeat ($urandom_range(0, 3)) queue_tick();
        end else if (r < 85) begin
          queue_noise_cmd();
        end else begin
          repeat ($urandom_range(1, 12)) queue_tick();
        end
      end
      drain();
      no_gaps = 1'b0;
    end

    // Anything still expected never arrived
    if (line_results_due.size() != 0)
      note_miss($sformatf("%0d results never arrived", line_results_due.size()));

    $display("Sent %0d beats, checked %0d results, %0d frames completed, %0d register writes.",
             beats_in, results_seen, frames_done, reg_writes);
    $display("Commands: %0d accepted, %0d invalid, %0d busy; %0d mismatches.",
             cmd_ok, cmd_invalid, cmd_busy, mismatches);
    if (mismatches == 0) begin
      $display("one_wire_pulse_width_command_sender_top_test passed");
    end else begin
      $display("one_wire_pulse_width_command_sender_top_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT);
    $display("one_wire_pulse_width_command_sender_top_test failed");
    $finish;
  end

endmodule
